@@ src/tkm_pkg.sv @@
// Shared types and constants for the trie keyword matcher.
// Used by tkm_ctrl, tkm_datapath and trie_keyword_matcher; no dependencies.
package tkm_pkg;

    localparam int ROW_COUNT_DEF = 256;
    localparam int ALPHABET_DEF  = 256;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // request command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_MISS_FIRST = 2'd1;
    localparam logic [1:0] ST_MISS_LATER = 2'd2;
    localparam logic [1:0] ST_FULL       = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic clear_start;  // clear request accepted
        logic item_start;   // insert/lookup request accepted, issue edge read
        logic sweep;        // clearing pass, one entry per cycle
        logic walk;         // edge data back, update walk state
        logic emit;         // load the result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sweep_done;
        logic last;
        logic out_free;
    } t_dp_status;

endpackage

@@ src/trie_keyword_matcher.sv @@
// Trie keyword matcher: insert and lookup of byte-string keywords in a row trie.
// Insert/lookup byte: edge read, then walk step; last byte: edge read, walk step with token access, result.
// Clear: a clearing pass over the rows in use, 2**ceil(log2(ALPHABET)) entries per row.
// After reset: a clearing pass over all ROW_COUNT rows, no request taken.
// One request in flight; a result waits in the output register. Past that, input stalls
// only in a clearing pass or when the next result is ready before the waiting one is taken.
// Depends on tkm_pkg, tkm_ctrl, tkm_datapath.
module trie_keyword_matcher #(
    parameter int ROW_COUNT = tkm_pkg::ROW_COUNT_DEF,
    parameter int ALPHABET  = tkm_pkg::ALPHABET_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_char_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_token_id,
    input  logic [7:0]  i_extra_value,
    input  logic        i_reset_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_found_id,
    output logic [1:0]  o_status,
    output logic [8:0]  o_rows_in_use,
    output logic [15:0] o_tokens_added
);

    tkm_pkg::t_dp_cmd    dp_cmd;
    tkm_pkg::t_dp_status dp_status;

    // extra value is stored nowhere observable; port kept for the request format
    logic unused_extra;
    assign unused_extra = ^i_extra_value;

    tkm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    tkm_datapath #(
        .ROW_COUNT (ROW_COUNT),
        .ALPHABET  (ALPHABET)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_dp_status    (dp_status),
        .i_command      (i_command),
        .i_char_byte    (i_char_byte),
        .i_last_byte    (i_last_byte),
        .i_token_id     (i_token_id),
        .i_reset_count  (i_reset_count),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_found_id     (o_found_id),
        .o_status       (o_status),
        .o_rows_in_use  (o_rows_in_use),
        .o_tokens_added (o_tokens_added)
    );

endmodule

@@ src/tkm_ctrl.sv @@
// Sequencer for the trie keyword matcher: clearing pass, byte walk, result.
// Depends on tkm_pkg.
module tkm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_command,
    output logic                o_in_ready,
    input  tkm_pkg::t_dp_status i_status,
    output tkm_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_SWEEP  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_WALK   = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   is_item;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign is_item    = (i_command == tkm_pkg::CMD_INSERT) ||
                        (i_command == tkm_pkg::CMD_LOOKUP);

    always_comb begin
        o_cmd.clear_start = accept && (i_command == tkm_pkg::CMD_CLEAR);
        o_cmd.item_start  = accept && is_item;
        o_cmd.sweep       = (r_state == S_SWEEP);
        o_cmd.walk        = (r_state == S_WALK);
        o_cmd.emit        = (r_state == S_RESULT) && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_SWEEP: begin
                if (i_status.sweep_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (o_cmd.clear_start) begin
                    n_state = S_SWEEP;
                end else if (o_cmd.item_start) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                n_state = i_status.last ? S_RESULT : S_IDLE;
            end
            S_RESULT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_SWEEP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/tkm_datapath.sv @@
// Trie row memories, walk state, counters and result register.
// Depends on tkm_pkg; driven by tkm_ctrl.
module tkm_datapath #(
    parameter int ROW_COUNT = tkm_pkg::ROW_COUNT_DEF,
    parameter int ALPHABET  = tkm_pkg::ALPHABET_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tkm_pkg::t_dp_cmd    i_cmd,
    output tkm_pkg::t_dp_status o_dp_status,
    input  logic [1:0]          i_command,
    input  logic [7:0]          i_char_byte,
    input  logic                i_last_byte,
    input  logic [15:0]         i_token_id,
    input  logic                i_reset_count,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [15:0]         o_found_id,
    output logic [1:0]          o_status,
    output logic [8:0]          o_rows_in_use,
    output logic [15:0]         o_tokens_added
);

    localparam int RW    = $clog2(ROW_COUNT);
    localparam int CW    = $clog2(ALPHABET);
    localparam int AW    = RW + CW;
    localparam int RCW   = $clog2(ROW_COUNT + 1);
    localparam int DEPTH = 1 << AW;

    // byte modulo alphabet by restoring subtraction, eight steps
    function automatic logic [7:0] mod_alpha(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        for (int k = 7; k >= 0; k--) begin
            if (32'(r) >= (ALPHABET << k)) r = 8'(32'(r) - (ALPHABET << k));
        end
        return r;
    endfunction

    logic [RW-1:0] nr_mem  [DEPTH];
    logic [15:0]   tok_mem [DEPTH];

    // control state
    logic [RCW-1:0] r_row_count, n_row_count;
    logic [15:0]    r_kw_count, n_kw_count;
    logic [RW-1:0]  r_cursor, n_cursor;
    logic           r_first, n_first;
    logic [1:0]     r_miss, n_miss;
    logic [AW-1:0]  r_sweep_addr, n_sweep_addr;
    logic [RW-1:0]  r_sweep_last_row, n_sweep_last_row;
    logic           r_out_valid, n_out_valid;

    // captured request and read data
    logic           r_insert;
    logic [CW-1:0]  r_char;
    logic           r_last;
    logic [15:0]    r_tok;
    logic [AW-1:0]  r_addr;
    logic [RW-1:0]  r_nr_rdata;
    logic [15:0]    r_tok_rdata;
    logic [1:0]     r_res_status;
    logic           r_res_lookup;
    logic [15:0]    r_out_found;
    logic [1:0]     r_out_status;
    logic [8:0]     r_out_rows;
    logic [15:0]    r_out_tokens;

    logic [RW-1:0]  a_row;
    logic [CW-1:0]  a_char;
    logic [AW-1:0]  a_addr;
    logic           w_need_row, w_full, w_alloc, w_hit;
    logic [RW-1:0]  w_new_row, w_cursor;
    logic [1:0]     w_miss;
    logic [AW-1:0]  w_end_addr;
    logic           nr_we, tok_we, tok_re;

    assign a_row  = r_first ? '0 : r_cursor;
    assign a_char = CW'(mod_alpha(i_char_byte));
    assign a_addr = {a_row, a_char};

    // walk step on the edge just read
    always_comb begin
        w_need_row = (r_miss == tkm_pkg::ST_OK) && r_insert && (r_nr_rdata == '0);
        w_full     = w_need_row && (r_row_count >= RCW'(ROW_COUNT));
        w_alloc    = w_need_row && !w_full;
        w_new_row  = RW'(r_row_count);
        if (r_miss != tkm_pkg::ST_OK) begin
            w_miss = r_miss;
        end else if (w_full) begin
            w_miss = tkm_pkg::ST_FULL;
        end else if (!r_insert && (r_nr_rdata == '0)) begin
            w_miss = r_first ? tkm_pkg::ST_MISS_FIRST : tkm_pkg::ST_MISS_LATER;
        end else begin
            w_miss = tkm_pkg::ST_OK;
        end
        if ((r_miss == tkm_pkg::ST_OK) && (w_miss == tkm_pkg::ST_OK)) begin
            w_cursor = w_alloc ? w_new_row : r_nr_rdata;
        end else begin
            w_cursor = r_cursor;
        end
        w_end_addr = {w_cursor, r_char};
        w_hit      = r_last && (w_miss == tkm_pkg::ST_OK);
    end

    assign nr_we  = i_cmd.walk && w_alloc;
    assign tok_we = i_cmd.walk && w_hit && r_insert;
    assign tok_re = i_cmd.walk && w_hit && !r_insert;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            nr_mem[r_sweep_addr] <= '0;
        end else if (nr_we) begin
            nr_mem[r_addr] <= w_new_row;
        end
        if (i_cmd.item_start) r_nr_rdata <= nr_mem[a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            tok_mem[r_sweep_addr] <= '0;
        end else if (tok_we) begin
            tok_mem[w_end_addr] <= r_tok;
        end
        if (tok_re) r_tok_rdata <= tok_mem[w_end_addr];
    end

    always_comb begin
        n_row_count      = r_row_count;
        n_kw_count       = r_kw_count;
        n_cursor         = r_cursor;
        n_first          = r_first;
        n_miss           = r_miss;
        n_sweep_addr     = r_sweep_addr;
        n_sweep_last_row = r_sweep_last_row;
        if (i_cmd.sweep) n_sweep_addr = r_sweep_addr + AW'(1);
        if (i_cmd.clear_start) begin
            n_sweep_addr     = '0;
            // rows at or above the fill count are still clean
            n_sweep_last_row = RW'(r_row_count - RCW'(1));
            n_row_count      = RCW'(1);
            n_cursor         = '0;
            n_first          = 1'b1;
            n_miss           = tkm_pkg::ST_OK;
            if (i_reset_count) n_kw_count = '0;
        end
        if (i_cmd.walk) begin
            if (w_alloc) n_row_count = r_row_count + RCW'(1);
            if (r_last) begin
                n_cursor = '0;
                n_first  = 1'b1;
                n_miss   = tkm_pkg::ST_OK;
                if (w_hit && r_insert && (r_kw_count != tkm_pkg::COUNT_MAX)) begin
                    n_kw_count = r_kw_count + 16'd1;
                end
            end else begin
                n_cursor = w_cursor;
                n_miss   = w_miss;
                if (r_miss == tkm_pkg::ST_OK) n_first = 1'b0;
            end
        end
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count      <= RCW'(1);
            r_kw_count       <= '0;
            r_cursor         <= '0;
            r_first          <= 1'b1;
            r_miss           <= tkm_pkg::ST_OK;
            r_sweep_addr     <= '0;
            r_sweep_last_row <= RW'(ROW_COUNT - 1);
            r_out_valid      <= 1'b0;
        end else begin
            r_row_count      <= n_row_count;
            r_kw_count       <= n_kw_count;
            r_cursor         <= n_cursor;
            r_first          <= n_first;
            r_miss           <= n_miss;
            r_sweep_addr     <= n_sweep_addr;
            r_sweep_last_row <= n_sweep_last_row;
            r_out_valid      <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_start) begin
            r_insert <= (i_command == tkm_pkg::CMD_INSERT);
            r_char   <= a_char;
            r_last   <= i_last_byte;
            r_tok    <= i_token_id;
            r_addr   <= a_addr;
        end
        if (i_cmd.walk) begin
            r_res_status <= w_miss;
            r_res_lookup <= w_hit && !r_insert;
        end
        if (i_cmd.emit) begin
            r_out_found  <= r_res_lookup ? r_tok_rdata : 16'd0;
            r_out_status <= r_res_status;
            r_out_rows   <= 9'(r_row_count);
            r_out_tokens <= r_kw_count;
        end
    end

    always_comb begin
        o_dp_status.sweep_done = (r_sweep_addr == {r_sweep_last_row, {CW{1'b1}}});
        o_dp_status.last       = r_last;
        o_dp_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_found_id     = r_out_found;
    assign o_status       = r_out_status;
    assign o_rows_in_use  = r_out_rows;
    assign o_tokens_added = r_out_tokens;

endmodule

@@ bench/tb_trie_keyword_matcher.sv @@
// Self-checking bench for trie_keyword_matcher: directed keywords, random traffic with
// every command code, and a full table, each checked against an in-bench trie.
// Depends on tkm_pkg and the trie_keyword_matcher RTL.
module tb_trie_keyword_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TRIE_ROWS      = tkm_pkg::ROW_COUNT_DEF;
    localparam int ALPHA          = tkm_pkg::ALPHABET_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 300;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int DICT_SIZE      = 64;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  char_byte;
        logic        last_byte;
        logic [15:0] token_id;
        logic [7:0]  extra_value;
        logic        reset_count;
    } t_trie_req;

    typedef struct packed {
        logic [15:0] found_id;
        logic [1:0]  status;
        logic [8:0]  rows_in_use;
        logic [15:0] tokens_added;
    } t_match_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_command;
    logic [7:0]  i_char_byte;
    logic        i_last_byte;
    logic [15:0] i_token_id;
    logic [7:0]  i_extra_value;
    logic        i_reset_count;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_found_id;
    logic [1:0]  o_status;
    logic [8:0]  o_rows_in_use;
    logic [15:0] o_tokens_added;

    trie_keyword_matcher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_char_byte   (i_char_byte),
        .i_last_byte   (i_last_byte),
        .i_token_id    (i_token_id),
        .i_extra_value (i_extra_value),
        .i_reset_count (i_reset_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found_id    (o_found_id),
        .o_status      (o_status),
        .o_rows_in_use (o_rows_in_use),
        .o_tokens_added(o_tokens_added)
    );

    // request stream and expected match results
    t_trie_req     pending_reqs[$];
    t_match_result expected_matches[$];
    int queued_total;
    int stim_count;
    int accepted;
    int sent_count;
    int results_seen;
    int mismatches;
    int stall_cycles;
    int hold_left;
    bit hold_used;
    logic req_taken;

    // predicted trie contents and walk state
    bit [7:0]  edge_row [0:TRIE_ROWS*ALPHA-1];
    bit [15:0] token_at [0:TRIE_ROWS*ALPHA-1];
    int        rows_used;
    int        keywords;
    int        walk_row;
    bit        at_first;
    bit [1:0]  walk_miss;

    // generator scratch: one keyword, and random keywords inserted since the last clear
    logic [7:0] word_buf [0:299];
    logic [7:0] dict_bytes [0:DICT_SIZE-1][0:4];
    int         dict_len [0:DICT_SIZE-1];
    int         dict_n;

    always #4 i_clk = ~i_clk;

    task automatic log_mismatch(input string what, input logic [15:0] got,
                                input logic [15:0] want);
        $display("error at %0t: %s got %0h, want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic trie_step(input t_trie_req r);
        int row;
        int nxt;
        int fin;
        int ch;
        t_match_result res;
        ch = int'(r.char_byte) % ALPHA;
        if (r.command == tkm_pkg::CMD_CLEAR) begin
            // only rows below rows_used can hold anything
            for (int i = 0; i < rows_used * ALPHA; i++) begin
                edge_row[i] = '0;
                token_at[i] = '0;
            end
            rows_used = 1;
            walk_row  = 0;
            at_first  = 1'b1;
            walk_miss = tkm_pkg::ST_OK;
            if (r.reset_count)
                keywords = 0;
        end else if (r.command != CMD_UNUSED) begin
            row = at_first ? 0 : walk_row;
            if (walk_miss == tkm_pkg::ST_OK) begin
                nxt = int'(edge_row[row * ALPHA + ch]);
                if (r.command == tkm_pkg::CMD_INSERT) begin
                    if (nxt == 0) begin
                        if (rows_used >= TRIE_ROWS) begin
                            walk_miss = tkm_pkg::ST_FULL;
                        end else begin
                            nxt = rows_used;
                            edge_row[row * ALPHA + ch] = nxt[7:0];
                            rows_used++;
                        end
                    end
                end else if (nxt == 0) begin
                    walk_miss = at_first ? tkm_pkg::ST_MISS_FIRST : tkm_pkg::ST_MISS_LATER;
                end
                if (walk_miss == tkm_pkg::ST_OK)
                    walk_row = nxt;
                at_first = 1'b0;
            end
            if (r.last_byte) begin
                res.found_id = '0;
                res.status   = walk_miss;
                if (walk_miss == tkm_pkg::ST_OK) begin
                    fin = walk_row * ALPHA + ch;
                    if (r.command == tkm_pkg::CMD_INSERT) begin
                        token_at[fin] = r.token_id;
                        if (keywords < int'(tkm_pkg::COUNT_MAX))
                            keywords++;
                    end else begin
                        res.found_id = token_at[fin];
                    end
                end
                res.rows_in_use  = rows_used[8:0];
                res.tokens_added = keywords[15:0];
                expected_matches.push_back(res);
                walk_row  = 0;
                at_first  = 1'b1;
                walk_miss = tkm_pkg::ST_OK;
            end
        end
    endtask

    task automatic queue_req(input logic [1:0] cmd, input logic [7:0] ch, input logic last,
                             input logic [15:0] tok, input logic [7:0] extra,
                             input logic rc);
        t_trie_req r;
        r.command     = cmd;
        r.char_byte   = ch;
        r.last_byte   = last;
        r.token_id    = tok;
        r.extra_value = extra;
        r.reset_count = rc;
        pending_reqs.push_back(r);
        if (cmd != CMD_UNUSED)
            stim_count++;
    endtask

    task automatic queue_word(input logic [1:0] cmd, input int len, input logic [15:0] tok,
                              input logic [7:0] extra);
        for (int i = 0; i < len; i++)
            queue_req(cmd, word_buf[i], i == len - 1, tok, extra, 1'($urandom_range(1)));
    endtask

    task automatic queue_clear(input logic rc);
        queue_req(tkm_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom_range(1)), 16'($urandom),
                  8'($urandom), rc);
        dict_n = 0;
    endtask

    // mostly a four-letter alphabet so keywords share prefixes
    function automatic logic [7:0] pick_char();
        if ($urandom_range(99) < 75)
            return 8'h61 + 8'($urandom_range(3));
        return 8'($urandom_range(255));
    endfunction

    function automatic int load_dict(input int k);
        for (int i = 0; i < dict_len[k]; i++)
            word_buf[i] = dict_bytes[k][i];
        return dict_len[k];
    endfunction

    task automatic queue_random_traffic();
        int roll;
        int len;
        int k;
        int stop_at;
        stop_at = stim_count + RANDOM_ITEMS;
        while (stim_count < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 3) begin
                queue_clear(1'($urandom_range(1)));
            end else if (roll < 7) begin
                queue_req(CMD_UNUSED, 8'($urandom), 1'($urandom_range(1)), 16'($urandom),
                          8'($urandom), 1'($urandom_range(1)));
            end else if (roll < 40 && dict_n < DICT_SIZE) begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    word_buf[i] = pick_char();
                    dict_bytes[dict_n][i] = word_buf[i];
                end
                dict_len[dict_n] = len;
                dict_n++;
                queue_word(tkm_pkg::CMD_INSERT, len, 16'($urandom), 8'($urandom));
            end else if (roll < 72 && dict_n > 0) begin
                // known keyword; now and then re-insert it with a new token
                len = load_dict($urandom_range(dict_n - 1));
                queue_word($urandom_range(4) == 0 ? tkm_pkg::CMD_INSERT : tkm_pkg::CMD_LOOKUP,
                           len, 16'($urandom), 8'($urandom));
            end else if (roll < 84) begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    word_buf[i] = pick_char();
                queue_word(tkm_pkg::CMD_LOOKUP, len, 16'($urandom), 8'($urandom));
            end else if (roll < 92 && dict_n > 0) begin
                // known prefix, then a byte that likely leaves the trie
                k = $urandom_range(dict_n - 1);
                len = $urandom_range(1, dict_len[k]);
                void'(load_dict(k));
                word_buf[len - 1] = pick_char();
                queue_word(tkm_pkg::CMD_LOOKUP, len, 16'($urandom), 8'($urandom));
            end else begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    queue_req($urandom_range(1) ? tkm_pkg::CMD_INSERT : tkm_pkg::CMD_LOOKUP,
                              pick_char(), i == len - 1, 16'($urandom), 8'($urandom),
                              1'($urandom_range(1)));
            end
        end
    endtask

    task automatic queue_directed();
        // miss on empty trie
        queue_req(tkm_pkg::CMD_LOOKUP, 8'h00, 1'b1, 16'hFFFF, 8'hFF, 1'b1);
        queue_req(tkm_pkg::CMD_INSERT, 8'hFF, 1'b1, 16'hFFFF, 8'hFF, 1'b1);
        queue_req(tkm_pkg::CMD_INSERT, 8'h00, 1'b0, 16'h5A5A, 8'h00, 1'b0);
        queue_req(tkm_pkg::CMD_INSERT, 8'hFF, 1'b1, 16'h5A5A, 8'h00, 1'b0);
        queue_req(tkm_pkg::CMD_LOOKUP, 8'hFF, 1'b1, 16'h0000, 8'h00, 1'b0);
        queue_req(tkm_pkg::CMD_LOOKUP, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b0);
        queue_req(tkm_pkg::CMD_LOOKUP, 8'hFF, 1'b1, 16'h0000, 8'h00, 1'b0);
        // miss on a later byte
        queue_req(tkm_pkg::CMD_LOOKUP, 8'h00, 1'b0, 16'h1111, 8'h11, 1'b0);
        queue_req(tkm_pkg::CMD_LOOKUP, 8'h01, 1'b0, 16'h1111, 8'h11, 1'b0);
        queue_req(tkm_pkg::CMD_LOOKUP, 8'h02, 1'b1, 16'h1111, 8'h11, 1'b0);
        queue_req(CMD_UNUSED, 8'hFF, 1'b1, 16'hFFFF, 8'hFF, 1'b1);
        // mixed commands
        queue_req(tkm_pkg::CMD_INSERT, 8'h00, 1'b0, 16'h2222, 8'h22, 1'b0);
        queue_req(tkm_pkg::CMD_LOOKUP, 8'hFF, 1'b1, 16'h2222, 8'h22, 1'b0);
        queue_req(tkm_pkg::CMD_LOOKUP, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b0);
        queue_req(tkm_pkg::CMD_INSERT, 8'h55, 1'b1, 16'h0000, 8'h00, 1'b0);
        // clear mid-keyword
        queue_req(tkm_pkg::CMD_INSERT, 8'h10, 1'b0, 16'h3333, 8'h33, 1'b0);
        queue_clear(1'b0);
        queue_req(tkm_pkg::CMD_LOOKUP, 8'hFF, 1'b1, 16'h0000, 8'h00, 1'b0);
        queue_clear(1'b1);
        queue_req(tkm_pkg::CMD_INSERT, 8'h7F, 1'b1, 16'h8001, 8'h80, 1'b0);
    endtask

    task automatic queue_full_table();
        queue_clear(1'b0);
        // a chain of zero bytes uses up every row, the rest of the keyword is swallowed
        for (int i = 0; i < 260; i++)
            word_buf[i] = 8'h00;
        queue_word(tkm_pkg::CMD_INSERT, 260, 16'h4444, 8'h44);
        queue_word(tkm_pkg::CMD_LOOKUP, 3, 16'h0000, 8'h00);
        queue_word(tkm_pkg::CMD_INSERT, 4, 16'hBEEF, 8'h01);   // path exists, still stored
        queue_word(tkm_pkg::CMD_LOOKUP, 4, 16'h0000, 8'h00);
        word_buf[0] = 8'h01;
        queue_word(tkm_pkg::CMD_INSERT, 1, 16'h5555, 8'h55);
        word_buf[0] = 8'h00;
        word_buf[2] = 8'h01;
        queue_word(tkm_pkg::CMD_INSERT, 3, 16'h6666, 8'h66);
        word_buf[0] = 8'h05;
        queue_word(tkm_pkg::CMD_LOOKUP, 1, 16'h0000, 8'h00);
        queue_clear(1'($urandom_range(1)));
    endtask

    // request driver: capture and predict at the rising edge, drive at the falling edge
    always @(posedge i_clk) begin
        t_trie_req r;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                r.command     = i_command;
                r.char_byte   = i_char_byte;
                r.last_byte   = i_last_byte;
                r.token_id    = i_token_id;
                r.extra_value = i_extra_value;
                r.reset_count = i_reset_count;
                trie_step(r);
                accepted++;
            end
        end
    end

    always @(negedge i_clk) begin
        t_trie_req r;
        if (i_rst_n && (!i_in_valid || req_taken)) begin
            if (pending_reqs.size() != 0 &&
                ((sent_count >= 150 && sent_count < 400) || $urandom_range(99) >= 6)) begin
                r = pending_reqs.pop_front();
                i_command     <= r.command;
                i_char_byte   <= r.char_byte;
                i_last_byte   <= r.last_byte;
                i_token_id    <= r.token_id;
                i_extra_value <= r.extra_value;
                i_reset_count <= r.reset_count;
                i_in_valid    <= 1'b1;
                sent_count++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side: one long hold-off early on, random stalls otherwise but for results 100 to 199
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (!hold_used && results_seen >= 30) begin
            hold_used   <= 1'b1;
            hold_left   <= 400;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= (results_seen >= 100 && results_seen < 200) ||
                           $urandom_range(99) >= 6;
        end
    end

    always @(posedge i_clk) begin
        t_match_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_matches.size() == 0) begin
                log_mismatch("unexpected result, found_id", o_found_id, 16'h0);
            end else begin
                want = expected_matches.pop_front();
                if (o_found_id !== want.found_id)
                    log_mismatch("found_id", o_found_id, want.found_id);
                if (o_status !== want.status)
                    log_mismatch("status", 16'(o_status), 16'(want.status));
                if (o_rows_in_use !== want.rows_in_use)
                    log_mismatch("rows_in_use", 16'(o_rows_in_use), 16'(want.rows_in_use));
                if (o_tokens_added !== want.tokens_added)
                    log_mismatch("tokens_added", o_tokens_added, want.tokens_added);
            end
        end
    end

    // watchdog; clearing passes run with no handshake at all
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_out_ready   = 1'b0;
        i_command     = tkm_pkg::CMD_CLEAR;
        i_char_byte   = '0;
        i_last_byte   = 1'b0;
        i_token_id    = '0;
        i_extra_value = '0;
        i_reset_count = 1'b0;
        rows_used     = 1;
        keywords      = 0;
        walk_row      = 0;
        at_first      = 1'b1;
        walk_miss     = tkm_pkg::ST_OK;
        dict_n        = 0;

        queue_directed();
        queue_random_traffic();
        queue_full_table();
        queued_total = pending_reqs.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (accepted != queued_total)
            @(posedge i_clk);
        while (expected_matches.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
